// ===== hw/rtl/wts_pkg.sv =====
package wts_pkg;

    localparam int POS_W       = 20;
    localparam int HEALTH_W    = 7;
    localparam int TERM_W      = 16;
    localparam int WEIGHT_W    = 16;
    localparam int INDEX_W     = 4;
    localparam int SCORE_W     = 34;
    localparam int PRODUCT_W   = WEIGHT_W + TERM_W;

    // sum of three squares of 20-bit magnitudes and its integer root
    localparam int SUMSQ_W     = 40;
    localparam int ROOT_W      = 20;
    localparam int ROOT_REM_W  = ROOT_W + 3;
    localparam int ROOT_STEPS  = SUMSQ_W / 2;

    // distance term: (1000 << 16) / (d + 1000), quotient known to fit 17 bits
    localparam int DIST_OFFSET    = 1000;
    localparam int DIST_NUM_SHIFT = 16;
    localparam int QUOT_W         = TERM_W + 1;
    localparam int DIVISOR_W      = ROOT_W;
    localparam int DIV_REM_W      = DIVISOR_W + 1;
    localparam logic [DIV_REM_W-1:0] DIV_REM_INIT =
        DIV_REM_W'((DIST_OFFSET << DIST_NUM_SHIFT) >> QUOT_W);

    // health term: (100 - h) * 65536 / 100 as a reciprocal multiply
    localparam int HEALTH_FULL        = 100;
    localparam int HEALTH_RECIP_W     = 22;
    localparam int HEALTH_RECIP_SHIFT = 12;
    localparam int HEALTH_PROD_W      = HEALTH_W + HEALTH_RECIP_W;
    localparam logic [HEALTH_RECIP_W-1:0] HEALTH_RECIP = 22'd2684355;

    localparam int STEP_W = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_WEIGHT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEALTH_WEIGHT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CONFIDENCE_WEIGHT = 2'd2;
    localparam logic [WEIGHT_W-1:0]    WEIGHT_ONE            = 16'h1000;

    typedef struct packed {
        logic [POS_W-1:0]   mag_x;
        logic [POS_W-1:0]   mag_y;
        logic [POS_W-1:0]   mag_z;
        logic [TERM_W-1:0]  health_term;
        logic [TERM_W-1:0]  confidence;
        logic [INDEX_W-1:0] index;
        logic               scored;
        logic               first;
        logic               last;
    } wts_item_t;

    typedef struct packed {
        wts_item_t         item;
        logic [ROOT_W-1:0] range_mm;
    } wts_job_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] distance;
        logic [WEIGHT_W-1:0] health;
        logic [WEIGHT_W-1:0] confidence;
    } wts_weights_t;

endpackage

// ===== hw/rtl/weighted_target_select.sv =====
// Picks the highest-priority target of a list, one target per input transfer, and
// returns its list position and Q6.28 score on the transfer marked last_target; on a
// tie the earlier target wins, and targets past MAX_TARGETS in a list are not scored.
// The front end takes a target into a two-entry queue, so short bursts are absorbed
// at full speed. Sustained rate is set by the distance unit, which takes a new target
// only once its last job has gone on: three squares on its one squaring multiplier and
// a 20-step integer square root, one result bit a cycle. The scoring unit behind it
// (17-step divide, three weight multiplies, compare) overlaps the next root.
// Weight registers: 0 distance, 1 health, 2 confidence, Q4.12, reset 1.0;
// writes are taken at once and belong in the gap between lists.
module weighted_target_select #(
    parameter int MAX_TARGETS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [wts_pkg::POS_W-1:0]         pos_x,
    input  logic signed [wts_pkg::POS_W-1:0]         pos_y,
    input  logic signed [wts_pkg::POS_W-1:0]         pos_z,
    input  logic        [wts_pkg::HEALTH_W-1:0]      health,
    input  logic        [wts_pkg::TERM_W-1:0]        confidence,
    input  logic                                     last_target,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic        [wts_pkg::INDEX_W-1:0]       best_index,
    output logic        [wts_pkg::SCORE_W-1:0]       top_score,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic        [wts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic        [wts_pkg::WEIGHT_W-1:0]      cfg_data
);

    wts_pkg::wts_weights_t weights_reg;
    wts_pkg::wts_weights_t weights_next;
    wts_pkg::wts_item_t    push_item;
    wts_pkg::wts_item_t    pop_item;
    wts_pkg::wts_job_t     job;
    logic                  push_valid;
    logic                  push_ready;
    logic                  pop_valid;
    logic                  pop_ready;
    logic                  job_valid;
    logic                  job_ready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        weights_next = weights_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                wts_pkg::REG_DISTANCE_WEIGHT:   weights_next.distance   = cfg_data;
                wts_pkg::REG_HEALTH_WEIGHT:     weights_next.health     = cfg_data;
                wts_pkg::REG_CONFIDENCE_WEIGHT: weights_next.confidence = cfg_data;
                default:                        weights_next            = weights_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg.distance   <= wts_pkg::WEIGHT_ONE;
            weights_reg.health     <= wts_pkg::WEIGHT_ONE;
            weights_reg.confidence <= wts_pkg::WEIGHT_ONE;
        end
        else
        begin
            weights_reg <= weights_next;
        end
    end

    wts_front #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .health      (health),
        .confidence  (confidence),
        .last_target (last_target),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    wts_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    wts_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .take_valid (pop_valid),
        .take_ready (pop_ready),
        .take_item  (pop_item),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job)
    );

    wts_score u_score (
        .clk        (clk),
        .rst_n      (rst_n),
        .weights    (weights_reg),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .best_index (best_index),
        .top_score  (top_score)
    );

endmodule

// ===== hw/rtl/wts_front.sv =====
module wts_front #(
    parameter int MAX_TARGETS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [wts_pkg::POS_W-1:0]     pos_x,
    input  logic signed [wts_pkg::POS_W-1:0]     pos_y,
    input  logic signed [wts_pkg::POS_W-1:0]     pos_z,
    input  logic        [wts_pkg::HEALTH_W-1:0]  health,
    input  logic        [wts_pkg::TERM_W-1:0]    confidence,
    input  logic                                 last_target,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output wts_pkg::wts_item_t                   push_item
);

    localparam int CNT_W = $clog2(MAX_TARGETS + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_TARGETS);

    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic                                scored;
    logic [wts_pkg::HEALTH_W-1:0]        health_sat;
    logic [wts_pkg::HEALTH_W-1:0]        deficit;
    logic [wts_pkg::HEALTH_PROD_W-1:0]   health_prod;
    logic [wts_pkg::QUOT_W-1:0]          health_full;

    function automatic logic [wts_pkg::POS_W-1:0] magnitude(
        input logic [wts_pkg::POS_W-1:0] v
    );
        magnitude = v[wts_pkg::POS_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign scored     = (count_reg < CNT_LIMIT);

    always_comb
    begin
        if (health > wts_pkg::HEALTH_W'(wts_pkg::HEALTH_FULL))
        begin
            health_sat = wts_pkg::HEALTH_W'(wts_pkg::HEALTH_FULL);
        end
        else
        begin
            health_sat = health;
        end
        deficit     = wts_pkg::HEALTH_W'(wts_pkg::HEALTH_FULL) - health_sat;
        health_prod = wts_pkg::HEALTH_PROD_W'(deficit)
                    * wts_pkg::HEALTH_PROD_W'(wts_pkg::HEALTH_RECIP);
        health_full = health_prod[wts_pkg::HEALTH_RECIP_SHIFT +: wts_pkg::QUOT_W];
    end

    always_comb
    begin
        push_item.mag_x       = magnitude(pos_x);
        push_item.mag_y       = magnitude(pos_y);
        push_item.mag_z       = magnitude(pos_z);
        push_item.health_term = health_full[wts_pkg::TERM_W] ? '1
                              : health_full[wts_pkg::TERM_W-1:0];
        push_item.confidence  = confidence;
        push_item.index       = wts_pkg::INDEX_W'(count_reg);
        push_item.scored      = scored;
        push_item.first       = (count_reg == '0);
        push_item.last        = last_target;
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_valid && push_ready)
        begin
            if (last_target)
            begin
                count_next = '0;
            end
            else if (scored)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/wts_fifo.sv =====
module wts_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  wts_pkg::wts_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output wts_pkg::wts_item_t pop_item
);

    wts_pkg::wts_item_t                slot_reg [wts_pkg::QUEUE_DEPTH];
    logic [wts_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [wts_pkg::QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [wts_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [wts_pkg::QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [wts_pkg::QUEUE_CNT_W-1:0]   fill_reg;
    logic [wts_pkg::QUEUE_CNT_W-1:0]   fill_next;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = (fill_reg != wts_pkg::QUEUE_CNT_W'(wts_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = wts_pkg::QUEUE_PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = wts_pkg::QUEUE_PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/wts_dist.sv =====
module wts_dist (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take_valid,
    output logic               take_ready,
    input  wts_pkg::wts_item_t take_item,
    output logic               job_valid,
    input  logic               job_ready,
    output wts_pkg::wts_job_t  job
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_ROOT   = 4'b0100,
        ST_HOLD   = 4'b1000
    } dist_state_t;

    dist_state_t                         state_reg;
    dist_state_t                         state_next;
    wts_pkg::wts_item_t                  item_reg;
    wts_pkg::wts_item_t                  item_next;
    logic [wts_pkg::STEP_W-1:0]          step_reg;
    logic [wts_pkg::STEP_W-1:0]          step_next;
    logic [wts_pkg::SUMSQ_W-1:0]         sumsq_reg;
    logic [wts_pkg::SUMSQ_W-1:0]         sumsq_next;
    logic [wts_pkg::ROOT_REM_W-1:0]      rem_reg;
    logic [wts_pkg::ROOT_REM_W-1:0]      rem_next;
    logic [wts_pkg::ROOT_W-1:0]          root_reg;
    logic [wts_pkg::ROOT_W-1:0]          root_next;
    logic [wts_pkg::POS_W-1:0]           mag_sel;
    logic [wts_pkg::SUMSQ_W-1:0]         square;
    logic [wts_pkg::ROOT_REM_W-1:0]      rem_shift;
    logic [wts_pkg::ROOT_REM_W-1:0]      trial;

    assign take_ready   = (state_reg == ST_IDLE);
    assign job_valid    = (state_reg == ST_HOLD);
    assign job.item     = item_reg;
    assign job.range_mm = root_reg;

    always_comb
    begin
        case (step_reg)
            wts_pkg::STEP_W'(0): mag_sel = item_reg.mag_x;
            wts_pkg::STEP_W'(1): mag_sel = item_reg.mag_y;
            default:             mag_sel = item_reg.mag_z;
        endcase
        square    = mag_sel * mag_sel;
        rem_shift = {rem_reg[wts_pkg::ROOT_REM_W-3:0],
                     sumsq_reg[wts_pkg::SUMSQ_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        step_next  = step_reg;
        sumsq_next = sumsq_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_valid)
                begin
                    item_next  = take_item;
                    step_next  = '0;
                    sumsq_next = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = take_item.scored ? ST_SQUARE : ST_HOLD;
                end
            end
            ST_SQUARE:
            begin
                sumsq_next = sumsq_reg + square;
                step_next  = step_reg + 1'b1;
                if (step_reg == wts_pkg::STEP_W'(2))
                begin
                    step_next  = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                sumsq_next = {sumsq_reg[wts_pkg::SUMSQ_W-3:0], 2'b00};
                if (rem_shift >= trial)
                begin
                    rem_next  = rem_shift - trial;
                    root_next = {root_reg[wts_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    root_next = {root_reg[wts_pkg::ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == wts_pkg::STEP_W'(wts_pkg::ROOT_STEPS - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (job_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        sumsq_reg <= sumsq_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
    end

endmodule

// ===== hw/rtl/wts_score.sv =====
module wts_score (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wts_pkg::wts_weights_t         weights,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  wts_pkg::wts_job_t             job,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [wts_pkg::INDEX_W-1:0]   best_index,
    output logic [wts_pkg::SCORE_W-1:0]   top_score
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_WEIGH  = 4'b0100,
        ST_DECIDE = 4'b1000
    } score_state_t;

    score_state_t                        state_reg;
    score_state_t                        state_next;
    wts_pkg::wts_item_t                  item_reg;
    wts_pkg::wts_item_t                  item_next;
    logic [wts_pkg::STEP_W-1:0]          step_reg;
    logic [wts_pkg::STEP_W-1:0]          step_next;
    logic [wts_pkg::DIVISOR_W-1:0]       divisor_reg;
    logic [wts_pkg::DIVISOR_W-1:0]       divisor_next;
    logic [wts_pkg::DIV_REM_W-1:0]       rem_reg;
    logic [wts_pkg::DIV_REM_W-1:0]       rem_next;
    logic [wts_pkg::QUOT_W-1:0]          quot_reg;
    logic [wts_pkg::QUOT_W-1:0]          quot_next;
    logic [wts_pkg::SCORE_W-1:0]         acc_reg;
    logic [wts_pkg::SCORE_W-1:0]         acc_next;
    logic [wts_pkg::INDEX_W-1:0]         leader_index_reg;
    logic [wts_pkg::INDEX_W-1:0]         leader_index_next;
    logic [wts_pkg::SCORE_W-1:0]         leader_score_reg;
    logic [wts_pkg::SCORE_W-1:0]         leader_score_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [wts_pkg::INDEX_W-1:0]         out_index_reg;
    logic [wts_pkg::INDEX_W-1:0]         out_index_next;
    logic [wts_pkg::SCORE_W-1:0]         out_score_reg;
    logic [wts_pkg::SCORE_W-1:0]         out_score_next;
    logic [wts_pkg::DIV_REM_W-1:0]       rem_shift;
    logic [wts_pkg::DIV_REM_W-1:0]       divisor_ext;
    logic [wts_pkg::TERM_W-1:0]          dist_term;
    logic [wts_pkg::WEIGHT_W-1:0]        weight_sel;
    logic [wts_pkg::TERM_W-1:0]          term_sel;
    logic [wts_pkg::PRODUCT_W-1:0]       product;
    logic                                take_lead;
    logic [wts_pkg::INDEX_W-1:0]         win_index;
    logic [wts_pkg::SCORE_W-1:0]         win_score;

    assign job_ready  = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign best_index = out_index_reg;
    assign top_score  = out_score_reg;

    always_comb
    begin
        rem_shift   = {rem_reg[wts_pkg::DIV_REM_W-2:0], 1'b0};
        divisor_ext = {1'b0, divisor_reg};
        dist_term   = quot_reg[wts_pkg::TERM_W] ? '1 : quot_reg[wts_pkg::TERM_W-1:0];
        case (step_reg)
            wts_pkg::STEP_W'(0):
            begin
                weight_sel = weights.distance;
                term_sel   = dist_term;
            end
            wts_pkg::STEP_W'(1):
            begin
                weight_sel = weights.health;
                term_sel   = item_reg.health_term;
            end
            default:
            begin
                weight_sel = weights.confidence;
                term_sel   = item_reg.confidence;
            end
        endcase
        product   = weight_sel * term_sel;
        take_lead = item_reg.scored && (item_reg.first || (acc_reg > leader_score_reg));
        win_index = take_lead ? item_reg.index : leader_index_reg;
        win_score = take_lead ? acc_reg : leader_score_reg;
    end

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        step_next         = step_reg;
        divisor_next      = divisor_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;
        acc_next          = acc_reg;
        leader_index_next = leader_index_reg;
        leader_score_next = leader_score_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_index_next    = out_index_reg;
        out_score_next    = out_score_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    item_next    = job.item;
                    divisor_next = job.range_mm
                                 + wts_pkg::DIVISOR_W'(wts_pkg::DIST_OFFSET);
                    rem_next     = wts_pkg::DIV_REM_INIT;
                    quot_next    = '0;
                    acc_next     = '0;
                    step_next    = '0;
                    state_next   = job.item.scored ? ST_DIVIDE : ST_DECIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (rem_shift >= divisor_ext)
                begin
                    rem_next  = rem_shift - divisor_ext;
                    quot_next = {quot_reg[wts_pkg::QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    quot_next = {quot_reg[wts_pkg::QUOT_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == wts_pkg::STEP_W'(wts_pkg::QUOT_W - 1))
                begin
                    step_next  = '0;
                    state_next = ST_WEIGH;
                end
            end
            ST_WEIGH:
            begin
                acc_next  = acc_reg + wts_pkg::SCORE_W'(product);
                step_next = step_reg + 1'b1;
                if (step_reg == wts_pkg::STEP_W'(2))
                begin
                    step_next  = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!item_reg.last)
                begin
                    leader_index_next = win_index;
                    leader_score_next = win_score;
                    state_next        = ST_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    out_index_next    = win_index;
                    out_score_next    = win_score;
                    leader_index_next = '0;
                    leader_score_next = '0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            leader_index_reg <= '0;
            leader_score_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            leader_index_reg <= leader_index_next;
            leader_score_reg <= leader_score_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        divisor_reg   <= divisor_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        acc_reg       <= acc_next;
        out_index_reg <= out_index_next;
        out_score_reg <= out_score_next;
    end

endmodule

// ===== hw/rtl/wts_checker.sv =====
module wts_checker #(
    parameter int MAX_TARGETS = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [wts_pkg::INDEX_W-1:0]         best_index,
    input logic [wts_pkg::SCORE_W-1:0]         top_score
);

    // three full weights times three full terms
    localparam logic [wts_pkg::SCORE_W-1:0] SCORE_LIMIT = 34'd12884508675;

    // a stalled result transfer holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(best_index) && $stable(top_score))
    else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> top_score <= SCORE_LIMIT)
    else $error("score above the largest weighted sum");

    // winner must come from a scored list position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (MAX_TARGETS >= 16) || (int'(best_index) < MAX_TARGETS))
    else $error("winning index beyond the scored positions");

endmodule

bind weighted_target_select wts_checker #(
    .MAX_TARGETS (MAX_TARGETS)
) u_wts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .best_index (best_index),
    .top_score  (top_score)
);

// ===== tb/sv/weighted_target_select_test.sv =====
`timescale 1ns / 100ps

module weighted_target_select_test;

    localparam int MAX_TGT = 16;
    localparam logic [wts_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 64;
    localparam logic [wts_pkg::TERM_W-1:0] TERM_MAX = 16'hFFFF;

    typedef struct {
        logic signed [wts_pkg::POS_W-1:0] x;
        logic signed [wts_pkg::POS_W-1:0] y;
        logic signed [wts_pkg::POS_W-1:0] z;
        logic [wts_pkg::HEALTH_W-1:0]     health;
        logic [wts_pkg::TERM_W-1:0]       conf;
        logic                             last;
    } target_t;

    typedef struct {
        logic [wts_pkg::INDEX_W-1:0] index;
        logic [wts_pkg::SCORE_W-1:0] score;
    } pick_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [wts_pkg::POS_W-1:0] pos_x = '0;
    logic signed [wts_pkg::POS_W-1:0] pos_y = '0;
    logic signed [wts_pkg::POS_W-1:0] pos_z = '0;
    logic [wts_pkg::HEALTH_W-1:0] health = '0;
    logic [wts_pkg::TERM_W-1:0] confidence = '0;
    logic last_target = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [wts_pkg::INDEX_W-1:0] best_index;
    logic [wts_pkg::SCORE_W-1:0] top_score;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [wts_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [wts_pkg::WEIGHT_W-1:0] cfg_data = '0;

    target_t target_queue[$];
    pick_t pending_picks[$];
    wts_pkg::wts_weights_t weights;
    int list_pos;
    int lead_index;
    logic [wts_pkg::SCORE_W-1:0] lead_score;
    bit lead_seen;
    bit in_taken = 1'b0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int errors = 0;

    weighted_target_select #(
        .MAX_TARGETS(MAX_TGT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .health(health),
        .confidence(confidence),
        .last_target(last_target),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .best_index(best_index),
        .top_score(top_score),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned b;
        rem = v;
        root = 0;
        b = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
            begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [wts_pkg::SCORE_W-1:0] target_score(input target_t t);
        longint sx;
        longint sy;
        longint sz;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned az;
        longint unsigned range_mm;
        longint unsigned dist_term;
        longint unsigned hp;
        longint unsigned health_term;
        longint unsigned total;
        sx = t.x;
        sy = t.y;
        sz = t.z;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        range_mm = int_sqrt(ax * ax + ay * ay + az * az);
        dist_term = (64'd1000 << 16) / (range_mm + 64'd1000);
        if (dist_term > TERM_MAX)
            dist_term = TERM_MAX;
        hp = t.health;
        if (hp > 100)
            hp = 100;
        health_term = ((100 - hp) << 16) / 100;
        if (health_term > TERM_MAX)
            health_term = TERM_MAX;
        total = longint'(weights.distance) * dist_term
              + longint'(weights.health) * health_term
              + longint'(weights.confidence) * longint'(t.conf);
        return total[wts_pkg::SCORE_W-1:0];
    endfunction

    function automatic void track_target(input target_t t);
        logic [wts_pkg::SCORE_W-1:0] s;
        pick_t p;
        if (list_pos < MAX_TGT)
        begin
            s = target_score(t);
            if (!lead_seen || s > lead_score)
            begin
                lead_score = s;
                lead_index = list_pos;
                lead_seen = 1'b1;
            end
            list_pos++;
        end
        if (t.last)
        begin
            p.index = lead_index[wts_pkg::INDEX_W-1:0];
            p.score = lead_score;
            pending_picks.push_back(p);
            list_pos = 0;
            lead_index = 0;
            lead_score = '0;
            lead_seen = 1'b0;
        end
    endfunction

    // monitor: weight updates, accepted targets, result checks
    always @(posedge clk)
    begin : monitor
        target_t t;
        pick_t p;
        in_taken = rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    wts_pkg::REG_DISTANCE_WEIGHT:   weights.distance = cfg_data;
                    wts_pkg::REG_HEALTH_WEIGHT:     weights.health = cfg_data;
                    wts_pkg::REG_CONFIDENCE_WEIGHT: weights.confidence = cfg_data;
                    default: ;
                endcase
            end
            if (in_taken)
            begin
                t.x = pos_x;
                t.y = pos_y;
                t.z = pos_z;
                t.health = health;
                t.conf = confidence;
                t.last = last_target;
                track_target(t);
            end
            if (out_valid && out_ready)
            begin
                if (pending_picks.size() == 0)
                begin
                    $display("%0t: result index %0d score %0d with nothing expected",
                             $time, best_index, top_score);
                    errors++;
                end
                else
                begin
                    p = pending_picks.pop_front();
                    if (best_index !== p.index)
                    begin
                        $display("%0t: best_index expected %0d actual %0d",
                                 $time, p.index, best_index);
                        errors++;
                    end
                    if (top_score !== p.score)
                    begin
                        $display("%0t: top_score expected %0d actual %0d",
                                 $time, p.score, top_score);
                        errors++;
                    end
                end
            end
        end
    end

    // driver: one target per transfer, random gaps and output stalls
    always @(negedge clk)
    begin : driver
        target_t t;
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
            if (!in_valid || in_taken)
            begin
                if (target_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    t = target_queue.pop_front();
                    in_valid <= 1'b1;
                    pos_x <= t.x;
                    pos_y <= t.y;
                    pos_z <= t.z;
                    health <= t.health;
                    confidence <= t.conf;
                    last_target <= t.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic add_target(input int x, input int y, input int z, input int h,
                              input int c, input bit last);
        target_t t;
        t.x = x[wts_pkg::POS_W-1:0];
        t.y = y[wts_pkg::POS_W-1:0];
        t.z = z[wts_pkg::POS_W-1:0];
        t.health = h[wts_pkg::HEALTH_W-1:0];
        t.conf = c[wts_pkg::TERM_W-1:0];
        t.last = last;
        target_queue.push_back(t);
    endtask

    function automatic int rand_coord(input int near_mode);
        int v;
        if (near_mode == 0)
            v = $urandom_range(3000) - 1500;
        else if (near_mode == 1)
            v = ($urandom_range(1) == 0) ? 0 : ($urandom_range(40) - 20);
        else
            v = $signed($urandom() << 12) >>> 12;
        return v;
    endfunction

    function automatic target_t rand_target();
        target_t t;
        int r;
        int mode;
        r = $urandom_range(99);
        mode = (r < 20) ? 0 : (r < 30) ? 1 : 2;
        t.x = wts_pkg::POS_W'(rand_coord(mode));
        t.y = wts_pkg::POS_W'(rand_coord(mode));
        t.z = wts_pkg::POS_W'(rand_coord(mode));
        r = $urandom_range(99);
        if (r < 80)
            t.health = wts_pkg::HEALTH_W'($urandom_range(100));
        else if (r < 90)
            t.health = ($urandom_range(1) == 0) ? 7'd0 : 7'd100;
        else
            t.health = wts_pkg::HEALTH_W'($urandom_range(127, 101));
        r = $urandom_range(99);
        if (r < 10)
            t.conf = '0;
        else if (r < 20)
            t.conf = TERM_MAX;
        else
            t.conf = wts_pkg::TERM_W'($urandom());
        t.last = 1'b0;
        return t;
    endfunction

    task automatic queue_random_list(output int n);
        target_t t;
        int r;
        r = $urandom_range(99);
        if (r < 10)
            n = 1;
        else if (r < 80)
            n = $urandom_range(MAX_TGT, 2);
        else if (r < 90)
            n = MAX_TGT;
        else
            n = $urandom_range(MAX_TGT + 4, MAX_TGT + 1);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(99) < 15)
                t.last = 1'b0;
            else
                t = rand_target();
            t.last = (i == n - 1);
            target_queue.push_back(t);
        end
    endtask

    task automatic queue_random_items(input int count);
        int done;
        int n;
        done = 0;
        while (done < count)
        begin
            queue_random_list(n);
            done += n;
        end
    endtask

    task automatic write_reg(input logic [wts_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [wts_pkg::WEIGHT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_weights(input logic [wts_pkg::WEIGHT_W-1:0] wd,
                                 input logic [wts_pkg::WEIGHT_W-1:0] wh,
                                 input logic [wts_pkg::WEIGHT_W-1:0] wc);
        write_reg(wts_pkg::REG_DISTANCE_WEIGHT, wd);
        write_reg(wts_pkg::REG_HEALTH_WEIGHT, wh);
        write_reg(wts_pkg::REG_CONFIDENCE_WEIGHT, wc);
    endtask

    task automatic wait_drained();
        while (target_queue.size() > 0 || in_valid || pending_picks.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        weights.distance = wts_pkg::WEIGHT_ONE;
        weights.health = wts_pkg::WEIGHT_ONE;
        weights.confidence = wts_pkg::WEIGHT_ONE;
        list_pos = 0;
        lead_index = 0;
        lead_score = '0;
        lead_seen = 1'b0;
        sender_idle_pct = 26;
        receiver_stall_pct = 79;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single target at the origin, full damage, full confidence
        add_target(0, 0, 0, 0, 65535, 1'b1);
        // extreme positions, health above full, tie on identical targets
        add_target(-524288, -524288, -524288, 127, 0, 1'b0);
        add_target(524287, 524287, 524287, 100, 0, 1'b0);
        add_target(524287, 524287, 524287, 100, 0, 1'b0);
        add_target(0, -1, 1, 50, 32768, 1'b1);
        // overlong list: best at the last scored slot, better ones past the limit
        for (int k = 0; k < 15; k++)
            add_target(k * 3000, -k * 700, 250, k * 6, k * 4000, 1'b0);
        add_target(10, 0, 0, 10, 50000, 1'b0);
        add_target(0, 0, 0, 0, 65535, 1'b0);
        add_target(0, 0, 0, 0, 65535, 1'b1);
        wait_drained();

        write_reg(REG_UNUSED, 16'h1234);
        write_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random_items(385);
        wait_drained();

        sender_idle_pct = 79;
        receiver_stall_pct = 26;
        write_weights(16'h0000, 16'h0000, 16'h0000);
        queue_random_items(385);
        wait_drained();

        write_weights(wts_pkg::WEIGHT_W'($urandom()), wts_pkg::WEIGHT_W'($urandom()),
                      wts_pkg::WEIGHT_W'($urandom()));
        queue_random_items(385);
        wait_drained();

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        write_weights(wts_pkg::WEIGHT_ONE, 16'hFFFF, 16'h0000);
        queue_random_items(385);
        wait_drained();

        write_weights(wts_pkg::WEIGHT_W'($urandom()), wts_pkg::WEIGHT_W'($urandom()),
                      wts_pkg::WEIGHT_W'($urandom()));
        queue_random_items(385);
        wait_drained();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/wts_pkg.sv
hw/rtl/wts_front.sv
hw/rtl/wts_fifo.sv
hw/rtl/wts_dist.sv
hw/rtl/wts_score.sv
hw/rtl/weighted_target_select.sv
hw/rtl/wts_checker.sv
tb/sv/weighted_target_select_test.sv
